### hw/rtl/edtc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package edtc_pkg;

    // Register reset values
    localparam logic [15:0] TARGET_RESET = 16'd120;
    localparam logic [14:0] JUMP_RESET   = 15'd1000;

    // Saturation limit of the tick count
    localparam logic [14:0] TICKS_MAX    = 15'h7FFF;

    // Restoring divider: one quotient bit per step over a 17-bit magnitude
    localparam int DIV_STEPS = 17;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    // Configuration register indexes
    localparam logic CFG_TARGET = 1'b0;
    localparam logic CFG_JUMP   = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WB
    } t_state;

endpackage

`default_nettype wire

### hw/rtl/encoder_distance_tick_counter.sv
// Each normal reading passes through capture, 17 divider steps and write-back;
// a jump reading skips the divider and goes from capture straight to write-back.
// A new reading is stalled until the current one has been written back.
// A finished result waits in the output register while the next reading is taken.
// Reset (synchronous, active low) restores target 120, jump limit 1000,
// previous reading 0 and remainder 0, and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module encoder_distance_tick_counter
    import edtc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration write port
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [15:0] i_count,
    // output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [14:0]             o_ticks,
    output logic                    o_jump_detected,
    output logic signed [16:0]      o_remainder
);

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [15:0]        r_target_pulses;
    logic [14:0]        r_jump_limit;
    logic [15:0]        r_prev;
    logic [17:0]        r_rem;
    logic [16:0]        r_part;
    logic [16:0]        r_quo;
    logic               r_neg;
    logic               r_jump;

    logic               w_in_acc;
    logic               w_out_free;
    logic               w_div_last;
    logic [15:0]        w_diff;
    logic [16:0]        w_mag;
    logic               w_jump;
    logic [17:0]        w_sum;
    logic [17:0]        w_abs;
    logic [16:0]        w_divisor;
    logic [17:0]        w_shift;
    logic [17:0]        w_trial;
    logic [14:0]        w_ticks;
    logic [16:0]        w_rem_out;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !o_out_valid || !i_out_stall;
    assign w_div_last = (r_cnt == CNT_W'(1));

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_pulses <= TARGET_RESET;
            r_jump_limit    <= JUMP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TARGET: r_target_pulses <= i_cfg_data;
                CFG_JUMP:   r_jump_limit    <= i_cfg_data[14:0];
                default:    ;
            endcase
        end
    end

    // Delta, jump test and new sum at capture
    assign w_diff = i_count - r_prev;
    assign w_mag  = w_diff[15] ? (17'h10000 - {1'b0, w_diff}) : {1'b0, w_diff};
    assign w_jump = w_mag > {2'b00, r_jump_limit};
    assign w_sum  = r_rem + {{2{w_diff[15]}}, w_diff};
    assign w_abs  = w_sum[17] ? (18'd0 - w_sum) : w_sum;

    // Zero target acts as 65536
    assign w_divisor = (r_target_pulses == 16'd0) ? 17'h10000 : {1'b0, r_target_pulses};

    // Shared divider step: shift in next dividend bit, trial subtract
    assign w_shift = {r_part, r_quo[16]};
    assign w_trial = w_shift - {1'b0, w_divisor};

    // Result formatting: saturate ticks, restore sign of remainder
    always_comb begin
        if (r_neg || r_jump) begin
            w_ticks = 15'd0;
        end else if (r_quo > {2'b00, TICKS_MAX}) begin
            w_ticks = TICKS_MAX;
        end else begin
            w_ticks = r_quo[14:0];
        end
        if (r_jump) begin
            w_rem_out = 17'd0;
        end else if (r_neg) begin
            w_rem_out = 17'd0 - r_part;
        end else begin
            w_rem_out = r_part;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_jump ? ST_WB : ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_last) begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture and divider datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= 16'd0;
            r_rem  <= 18'd0;
            r_cnt  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_prev <= i_count;
                        r_jump <= w_jump;
                        r_neg  <= w_sum[17];
                        r_quo  <= w_abs[16:0];
                        r_part <= 17'd0;
                        r_cnt  <= CNT_W'(DIV_STEPS);
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (!w_trial[17]) begin
                        r_part <= w_trial[16:0];
                        r_quo  <= {r_quo[15:0], 1'b1};
                    end else begin
                        r_part <= w_shift[16:0];
                        r_quo  <= {r_quo[15:0], 1'b0};
                    end
                end
                ST_WB: begin
                    if (w_out_free) begin
                        r_rem <= {w_rem_out[16], w_rem_out};
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == ST_WB && w_out_free) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WB && w_out_free) begin
            o_ticks         <= w_ticks;
            o_jump_detected <= r_jump;
            o_remainder     <= w_rem_out;
        end
    end

    // Checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("input not stalled after a transaction");

    a_jump_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_jump_detected) |-> (o_ticks == 15'd0 && o_remainder == 17'sd0))
        else $error("jump result carries ticks or remainder");

    a_neg_no_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_remainder[16]) |-> (o_ticks == 15'd0))
        else $error("negative remainder with ticks");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DIV_STEPS))
        else $error("divider step counter out of range");

    a_div_to_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && w_div_last) |=> (r_state == ST_WB))
        else $error("divider did not hand over to write-back");

endmodule

`default_nettype wire

### dv/tick_count_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts each reading's result
// and compares it with what the counter hands out.
module tick_count_checker
    import edtc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire logic signed [15:0] i_count,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic [14:0]        i_ticks,
    input  wire logic               i_jump_detected,
    input  wire logic signed [16:0] i_remainder,
    output int                      o_mismatches,
    output int                      o_outstanding
);

    typedef struct packed {
        logic [14:0]        ticks;
        logic               jump;
        logic signed [16:0] rem;
    } tick_result_t;

    // Shadow registers and accumulator state
    logic [15:0] target_pulses_q = TARGET_RESET;
    logic [14:0] jump_limit_q    = JUMP_RESET;
    logic [15:0] last_count_q    = '0;
    int          pulse_rem_q     = 0;

    tick_result_t due_results[$];
    int           mismatch_total = 0;
    int           pending_total  = 0;

    assign o_mismatches  = mismatch_total;
    assign o_outstanding = pending_total;

    // One reading: wrapped delta, jump test, then fold into the remainder
    function automatic tick_result_t advance_odometer(input logic [15:0] reading);
        logic [15:0]  diff;
        int           delta;
        int           mag;
        int           divisor;
        int           sum;
        int           quot;
        tick_result_t res;
        diff    = reading - last_count_q;
        delta   = $signed(diff);
        mag     = (delta < 0) ? -delta : delta;
        // zero target behaves as 65536
        divisor = (target_pulses_q == '0) ? 65536 : int'(target_pulses_q);
        res     = '0;
        if (mag > int'(jump_limit_q)) begin
            pulse_rem_q = 0;
            res.jump    = 1'b1;
        end else begin
            sum = pulse_rem_q + delta;
            if (sum >= divisor) begin
                quot      = sum / divisor;
                res.ticks = (quot > int'(TICKS_MAX)) ? TICKS_MAX : quot[14:0];
                sum       = sum % divisor;
            end else if (sum <= -divisor) begin
                // backwards: truncate towards zero, no ticks
                sum = -((-sum) % divisor);
            end
            pulse_rem_q = sum;
        end
        last_count_q = reading;
        res.rem      = pulse_rem_q[16:0];
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        tick_result_t want;
        if (!i_rst_n) begin
            target_pulses_q = TARGET_RESET;
            jump_limit_q    = JUMP_RESET;
            last_count_q    = '0;
            pulse_rem_q     = 0;
            due_results.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TARGET: target_pulses_q = i_cfg_data;
                    CFG_JUMP:   jump_limit_q    = i_cfg_data[14:0];
                    default: ;
                endcase
            end

            // result transaction against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= 10)
                        $display("%0t: result with nothing pending: ticks %0d jump %0b rem %0d",
                                 $realtime, i_ticks, i_jump_detected, i_remainder);
                end else begin
                    want = due_results.pop_front();
                    if (want.ticks !== i_ticks || want.jump !== i_jump_detected ||
                        want.rem !== i_remainder) begin
                        mismatch_total++;
                        if (mismatch_total <= 10)
                            $display("%0t: mismatch: ticks %0d/%0d jump %0b/%0b rem %0d/%0d %s",
                                     $realtime, want.ticks, i_ticks, want.jump,
                                     i_jump_detected, want.rem, i_remainder,
                                     "(expected/actual)");
                    end
                end
            end

            // reading transaction
            if (i_in_valid && !i_in_stall)
                due_results.push_back(advance_odometer(i_count));
        end
        pending_total <= due_results.size();
    end

endmodule

### dv/encoder_distance_tick_counter_test.sv
`timescale 1ns / 1ps

module encoder_distance_tick_counter_test;
    import edtc_pkg::*;

    localparam int CLK_HALF        = 2;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int BURST           = 50;
    localparam int SETTLE_CYCLES   = 40;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic               cfg_index = CFG_TARGET;
    logic [15:0]        cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic signed [15:0] count     = '0;
    logic               out_stall = 1'b0;

    wire logic               in_stall;
    wire logic               out_valid;
    wire logic [14:0]        ticks;
    wire logic               jump_detected;
    wire logic signed [16:0] remainder;

    int          mismatches;
    int          outstanding;
    int          cycles       = 0;
    bit          feed_gaps    = 1'b1;
    bit          drain_stalls = 1'b1;
    logic [15:0] last_reading = '0;

    encoder_distance_tick_counter DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_count         (count),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_ticks         (ticks),
        .o_jump_detected (jump_detected),
        .o_remainder     (remainder)
    );

    tick_count_checker u_tick_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_count         (count),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_ticks         (ticks),
        .i_jump_detected (jump_detected),
        .i_remainder     (remainder),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    initial begin
        forever #CLK_HALF clk = ~clk;
    end

    // Watchdog
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Result side: random hold-off before each transaction
    initial begin
        int hold;
        forever begin
            hold = drain_stalls ? $urandom_range(0, 19) : 0;
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // One reading transaction, after a random gap
    task automatic send_reading(input logic [15:0] value);
        int gap;
        gap = feed_gaps ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        count        <= value;
        last_reading  = value;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_delta(input int delta);
        send_reading(last_reading + 16'(delta));
    endtask

    // Hold the readings back until every predicted result has come out
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Top bit of the jump limit write is don't-care; toggle it anyway
    task automatic configure(input logic [15:0] target, input logic [14:0] limit);
        write_reg(CFG_TARGET, target);
        write_reg(CFG_JUMP, {1'($urandom_range(0, 1)), limit});
    endtask

    // Delta for the next reading: mostly plausible motion, some jumps and noise
    function automatic int choose_step(input int limit);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            return int'($urandom_range(0, 2 * limit)) - limit;
        if (pick < 55)
            return int'($urandom_range(0, limit));
        if (pick < 65)
            return pick[0] ? limit : -limit;
        if (pick < 73)
            return (limit >= 32767) ? -32768 : (pick[0] ? limit + 1 : -(limit + 1));
        if (pick < 80)
            return -32768;
        if (pick < 90)
            return int'($urandom_range(0, 6)) - 3;
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    initial begin
        int target_val;
        int limit_val;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: target 120, jump limit 1000
        send_delta(0);
        send_delta(120);
        send_delta(999);
        send_delta(1000);        // right at the limit
        send_delta(1001);        // just over: jump
        send_delta(-1000);       // backwards past minus target
        send_delta(-32768);      // most negative delta always jumps
        send_reading(16'h7FFF);
        send_reading(16'h8000);  // counter wraps forwards
        send_reading(16'h8001);

        // Zero target counts as 65536
        configure(16'd0, 15'd32767);
        send_delta(-32768);
        send_delta(32767);
        send_delta(32767);
        send_delta(2);
        send_delta(-32767);
        send_delta(-32767);
        send_delta(-2);

        // Unit target: large tick counts
        configure(16'd1, 15'd32767);
        send_delta(32767);
        send_delta(-5);

        // Largest target, zero jump limit
        configure(16'hFFFF, 15'd0);
        send_delta(0);
        send_delta(1);
        send_delta(-1);

        // Random phases over a spread of settings
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin target_val = TARGET_RESET;   limit_val = JUMP_RESET; end
                1: begin target_val = 1;              limit_val = 32767;      end
                2: begin target_val = 65535;          limit_val = 32767;      end
                3: begin target_val = 0;              limit_val = 32767;      end
                4: begin target_val = 3;              limit_val = 0;          end
                5: begin
                    target_val = $urandom_range(2, 500);
                    limit_val  = $urandom_range(1, 32767);
                end
                default: begin
                    target_val = $urandom_range(0, 65535);
                    limit_val  = $urandom_range(0, 32767);
                end
            endcase
            configure(16'(target_val), 15'(limit_val));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % BURST == 0) begin
                    feed_gaps    = ($urandom_range(0, 3) != 0) && (phase != 2);
                    drain_stalls = ($urandom_range(0, 3) != 0) && (phase != 2);
                end
                if (n == ITEMS_PER_PHASE / 2 && phase[0])
                    settle();
                send_delta(choose_step(limit_val));
            end
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
